// ===== rtl/hgcd_pkg.sv =====
`timescale 1ns / 1ps

package hgcd_pkg;

   // Position smoothing history depth (2 to 8)
   localparam int POS_HISTORY  = 4;
   // Corner-count history: four older counts and two recent ones
   localparam int CORNER_DEPTH = 6;

   localparam int POS_W     = 10;
   localparam int CORNER_W  = 12;
   localparam int CUR_W     = 16;
   localparam int FRAC_W    = 6;
   localparam int CNT_W     = 4;

   localparam int HFILL_W   = $clog2(POS_HISTORY + 1);
   localparam int HIDX_W    = $clog2(POS_HISTORY);
   localparam int CFILL_W   = $clog2(CORNER_DEPTH + 1);

   // Divider: divisor is fill + 1, dividend is new point plus stored points
   localparam int DIVR_W    = $clog2(POS_HISTORY + 2);
   localparam int SUM_W     = CUR_W + $clog2(POS_HISTORY + 1);
   localparam int DIV_BITS  = 3;
   localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIVD_W    = DIV_STEPS * DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_DROP_MARGIN   = 2'd0;
   localparam logic [1:0] REG_MOVE_THRESH   = 2'd1;
   localparam logic [1:0] REG_HOLD_FRAMES   = 2'd2;
   localparam logic [1:0] REG_DECAY_FRAMES  = 2'd3;

   localparam logic [11:0] RST_DROP_MARGIN  = 12'd150;
   localparam logic [9:0]  RST_MOVE_THRESH  = 10'd12;
   localparam logic [3:0]  RST_HOLD_FRAMES  = 4'd8;
   localparam logic [3:0]  RST_DECAY_FRAMES = 4'd10;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_MOVE   = 2'd1,
      MODE_CLICK  = 2'd2,
      MODE_DRAG   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_MOVE  = 3'd1,
      EV_DRAG  = 3'd2,
      EV_DOWN  = 3'd3,
      EV_UP    = 3'd4,
      EV_CLICK = 3'd5
   } event_type;

   typedef struct packed {
      logic [11:0] drop_margin;
      logic [9:0]  move_threshold;
      logic [3:0]  hold_frames;
      logic [3:0]  move_decay_frames;
   } cfg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic decide;
      logic speed;
      logic emit;
   } cmd_type;

endpackage

// ===== rtl/hgcd_csr.sv =====
`timescale 1ns / 1ps

module hgcd_csr import hgcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Write the addressed register in the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_margin       <= RST_DROP_MARGIN;
         cfg_ff.move_threshold    <= RST_MOVE_THRESH;
         cfg_ff.hold_frames       <= RST_HOLD_FRAMES;
         cfg_ff.move_decay_frames <= RST_DECAY_FRAMES;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_DROP_MARGIN:  cfg_ff.drop_margin       <= pwdata[11:0];
            REG_MOVE_THRESH:  cfg_ff.move_threshold    <= pwdata[9:0];
            REG_HOLD_FRAMES:  cfg_ff.hold_frames       <= pwdata[3:0];
            REG_DECAY_FRAMES: cfg_ff.move_decay_frames <= pwdata[3:0];
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (paddr[3:2])
         REG_DROP_MARGIN:  prdata = CSR_DATA_W'(cfg_ff.drop_margin);
         REG_MOVE_THRESH:  prdata = CSR_DATA_W'(cfg_ff.move_threshold);
         REG_HOLD_FRAMES:  prdata = CSR_DATA_W'(cfg_ff.hold_frames);
         REG_DECAY_FRAMES: prdata = CSR_DATA_W'(cfg_ff.move_decay_frames);
      endcase
   end

endmodule

// ===== rtl/hgcd_ctrl.sv =====
`timescale 1ns / 1ps

module hgcd_ctrl import hgcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DIV    = 5'b00010,
      S_DECIDE = 5'b00100,
      S_SPEED  = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one item: load, divide, decide, speed check, emit
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DECIDE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_SPEED;
         end
         S_SPEED: begin
            cmd.speed = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // Wait until the output register is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result valid until the receiver takes it
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command active");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result emitted over an item not yet taken");

   a_load_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_DIV && step_ff == '0))
      else $error("accepted item did not start the divider");

endmodule

// ===== rtl/hgcd_dpath.sv =====
`timescale 1ns / 1ps

module hgcd_dpath import hgcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  cfg_type             cfg,
   input  logic [POS_W-1:0]    pos_x,
   input  logic [POS_W-1:0]    pos_y,
   input  logic [CORNER_W-1:0] corner_count,
   output logic [2:0]          event_res,
   output logic [1:0]          mode,
   output logic [CUR_W-1:0]    cursor_x,
   output logic [CUR_W-1:0]    cursor_y
);

   // Control state
   mode_type             mode_ff, mode_in;
   logic [HFILL_W-1:0]   hfill_ff, hfill_in;
   logic [CFILL_W-1:0]   cfill_ff, cfill_in;
   logic [CORNER_W-1:0]  release_ff, release_in;
   logic [CNT_W-1:0]     hold_ff, hold_in;
   logic [CNT_W-1:0]     quiet_ff, quiet_in;
   logic                 speed_ff, speed_in;

   // Payload state
   logic [CUR_W-1:0]     hist_x_ff [POS_HISTORY];
   logic [CUR_W-1:0]     hist_y_ff [POS_HISTORY];
   logic [CORNER_W-1:0]  chist_ff [CORNER_DEPTH];
   logic [CORNER_W-1:0]  corner_ff;
   event_type            ev_ff, ev_in;
   logic [DIVD_W-1:0]    qx_ff, qy_ff;
   logic [DIVR_W-1:0]    rx_ff, ry_ff;
   logic [DIVR_W-1:0]    dvs_ff;
   event_type            ev_out_ff;
   mode_type             mode_out_ff;
   logic [CUR_W-1:0]     curx_out_ff, cury_out_ff;

   // Combinational
   logic [SUM_W-1:0]      sum_x, sum_y;
   logic [DIVR_W+DIVD_W-1:0] stp_x, stp_y;
   logic [CUR_W-1:0]      sx, sy;
   logic                  cfull, hfull, click_on, consumed, store;
   logic [CORNER_W+1:0]   old_sum;
   logic [CORNER_W:0]     recent_sum;
   logic [CORNER_W-1:0]   old_mean, recent_mean;
   logic                  drop, rise;
   logic [CNT_W:0]        hold_n, quiet_n;
   mode_type              dec_mode;
   logic [CORNER_W-1:0]   dec_release;
   logic [CNT_W-1:0]      dec_hold;
   logic [HIDX_W-1:0]     last_idx;
   logic [CUR_W-1:0]      last_x, last_y, dx, dy;
   logic [CUR_W:0]        travel, thr;
   logic                  big;

   // One radix-8 restoring step: three quotient bits
   function automatic logic [DIVR_W+DIVD_W-1:0] div_step(
      input logic [DIVR_W-1:0] rem,
      input logic [DIVD_W-1:0] quo,
      input logic [DIVR_W-1:0] dvs
   );
      logic [DIVR_W:0]   part;
      logic [DIVR_W-1:0] r;
      logic [DIVD_W-1:0] q;
      r = rem;
      q = quo;
      for (int b = 0; b < DIV_BITS; b++) begin
         part = {r, q[DIVD_W-1]};
         q    = {q[DIVD_W-2:0], 1'b0};
         if (part >= {1'b0, dvs}) begin
            part = part - {1'b0, dvs};
            q[0] = 1'b1;
         end
         r = part[DIVR_W-1:0];
      end
      return {r, q};
   endfunction

   // Sum the new point with the stored points
   always_comb begin
      sum_x = SUM_W'({pos_x, {FRAC_W{1'b0}}});
      sum_y = SUM_W'({pos_y, {FRAC_W{1'b0}}});
      for (int i = 0; i < POS_HISTORY; i++) begin
         if (HFILL_W'(i) < hfill_ff) begin
            sum_x = sum_x + SUM_W'(hist_x_ff[i]);
            sum_y = sum_y + SUM_W'(hist_y_ff[i]);
         end
      end
   end

   assign stp_x = div_step(rx_ff, qx_ff, dvs_ff);
   assign stp_y = div_step(ry_ff, qy_ff, dvs_ff);
   assign sx    = qx_ff[CUR_W-1:0];
   assign sy    = qy_ff[CUR_W-1:0];

   // Corner means over the shifted history
   assign cfull       = (cfill_ff == CFILL_W'(CORNER_DEPTH));
   assign hfull       = (hfill_ff == HFILL_W'(POS_HISTORY));
   assign click_on    = (mode_ff != MODE_MOVE);
   assign old_sum     = (CORNER_W+2)'(chist_ff[1]) + (CORNER_W+2)'(chist_ff[2])
                      + (CORNER_W+2)'(chist_ff[3]) + (CORNER_W+2)'(chist_ff[4]);
   assign recent_sum  = (CORNER_W+1)'(chist_ff[5]) + (CORNER_W+1)'(corner_ff);
   assign old_mean    = old_sum[CORNER_W+1:2];
   assign recent_mean = recent_sum[CORNER_W:1];
   assign drop = ({1'b0, recent_mean} + {1'b0, cfg.drop_margin}) < {1'b0, old_mean};
   assign rise = {1'b0, recent_mean} > ({1'b0, release_ff} + {1'b0, cfg.drop_margin});
   assign hold_n  = {1'b0, hold_ff} + (CNT_W+1)'(1);
   assign quiet_n = {1'b0, quiet_ff} + (CNT_W+1)'(1);

   // Decide click transitions, event and whether the point is stored
   always_comb begin
      dec_mode    = mode_ff;
      dec_release = release_ff;
      dec_hold    = hold_ff;
      ev_in       = EV_NONE;
      consumed    = 1'b0;
      store       = 1'b0;
      speed_in    = 1'b0;
      if (click_on && cfull) begin
         priority if (mode_ff == MODE_NORMAL && drop) begin
            dec_release = recent_mean;
            dec_mode    = MODE_CLICK;
            dec_hold    = '0;
            consumed    = 1'b1;
         end else if (rise && mode_ff == MODE_DRAG) begin
            ev_in    = EV_UP;
            dec_mode = MODE_NORMAL;
            consumed = 1'b1;
         end else if (rise && mode_ff == MODE_CLICK) begin
            ev_in    = EV_CLICK;
            dec_mode = MODE_NORMAL;
            consumed = 1'b1;
         end else if (mode_ff == MODE_CLICK) begin
            dec_hold = hold_n[CNT_W] ? {CNT_W{1'b1}} : hold_n[CNT_W-1:0];
            if (hold_n > {1'b0, cfg.hold_frames}) begin
               dec_mode = MODE_DRAG;
               ev_in    = EV_DOWN;
               dec_hold = '0;
            end
         end else begin
            dec_hold = hold_ff;
         end
      end
      unique case (mode_ff)
         MODE_NORMAL: begin
            if (!consumed) begin
               store    = 1'b1;
               ev_in    = EV_MOVE;
               speed_in = 1'b1;
            end
         end
         MODE_MOVE: begin
            store    = 1'b1;
            ev_in    = EV_MOVE;
            speed_in = 1'b1;
         end
         MODE_DRAG: begin
            if (!consumed) begin
               store = 1'b1;
               ev_in = EV_DRAG;
            end
         end
         MODE_CLICK: begin
            store = 1'b0;
         end
      endcase
   end

   // Displacement between oldest and newest stored points
   assign last_idx = HIDX_W'(hfill_ff - HFILL_W'(1));
   assign last_x   = hist_x_ff[last_idx];
   assign last_y   = hist_y_ff[last_idx];
   assign dx   = (hist_x_ff[0] >= last_x) ? hist_x_ff[0] - last_x : last_x - hist_x_ff[0];
   assign dy   = (hist_y_ff[0] >= last_y) ? hist_y_ff[0] - last_y : last_y - hist_y_ff[0];
   assign travel = {1'b0, dx} + {1'b0, dy};
   assign thr    = {1'b0, cfg.move_threshold, {FRAC_W{1'b0}}};
   assign big    = travel > thr;

   // Next values of the control state
   always_comb begin
      mode_in    = mode_ff;
      release_in = release_ff;
      hold_in    = hold_ff;
      quiet_in   = quiet_ff;
      hfill_in   = hfill_ff;
      cfill_in   = cfill_ff;
      if (cmd.decide) begin
         mode_in    = dec_mode;
         release_in = dec_release;
         hold_in    = dec_hold;
         if (click_on && !cfull) begin
            cfill_in = cfill_ff + CFILL_W'(1);
         end
         if (store && !hfull) begin
            hfill_in = hfill_ff + HFILL_W'(1);
         end
      end else if (cmd.speed && speed_ff) begin
         if (big) begin
            mode_in  = MODE_MOVE;
            quiet_in = '0;
         end else if (mode_ff == MODE_MOVE) begin
            quiet_in = quiet_n[CNT_W] ? {CNT_W{1'b1}} : quiet_n[CNT_W-1:0];
            if (quiet_n > {1'b0, cfg.move_decay_frames}) begin
               mode_in = MODE_NORMAL;
            end
         end else begin
            mode_in = MODE_NORMAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         hfill_ff   <= '0;
         cfill_ff   <= '0;
         release_ff <= '0;
         hold_ff    <= '0;
         quiet_ff   <= '0;
         speed_ff   <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         hfill_ff   <= hfill_in;
         cfill_ff   <= cfill_in;
         release_ff <= release_in;
         hold_ff    <= hold_in;
         quiet_ff   <= quiet_in;
         if (cmd.decide) begin
            speed_ff <= speed_in;
         end
      end
   end

   // Load and advance the divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qx_ff     <= DIVD_W'(sum_x);
         qy_ff     <= DIVD_W'(sum_y);
         rx_ff     <= '0;
         ry_ff     <= '0;
         dvs_ff    <= DIVR_W'(hfill_ff) + DIVR_W'(1);
         corner_ff <= corner_count;
      end else if (cmd.step) begin
         {rx_ff, qx_ff} <= stp_x;
         {ry_ff, qy_ff} <= stp_y;
      end
   end

   // Update the corner and position histories
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         ev_ff <= ev_in;
         if (click_on) begin
            if (cfull) begin
               for (int i = 0; i < CORNER_DEPTH - 1; i++) begin
                  chist_ff[i] <= chist_ff[i+1];
               end
               chist_ff[CORNER_DEPTH-1] <= corner_ff;
            end else begin
               for (int i = 0; i < CORNER_DEPTH; i++) begin
                  if (CFILL_W'(i) == cfill_ff) begin
                     chist_ff[i] <= corner_ff;
                  end
               end
            end
         end
         if (store) begin
            if (hfull) begin
               for (int i = 0; i < POS_HISTORY - 1; i++) begin
                  hist_x_ff[i] <= hist_x_ff[i+1];
                  hist_y_ff[i] <= hist_y_ff[i+1];
               end
               hist_x_ff[POS_HISTORY-1] <= sx;
               hist_y_ff[POS_HISTORY-1] <= sy;
            end else begin
               for (int i = 0; i < POS_HISTORY; i++) begin
                  if (HFILL_W'(i) == hfill_ff) begin
                     hist_x_ff[i] <= sx;
                     hist_y_ff[i] <= sy;
                  end
               end
            end
         end
      end
   end

   // Capture the result item
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         ev_out_ff   <= ev_ff;
         mode_out_ff <= mode_ff;
         curx_out_ff <= (hfill_ff != '0) ? last_x : '0;
         cury_out_ff <= (hfill_ff != '0) ? last_y : '0;
      end
   end

   assign event_res = ev_out_ff;
   assign mode      = mode_out_ff;
   assign cursor_x  = curx_out_ff;
   assign cursor_y  = cury_out_ff;

   a_hfill_max: assert property (@(posedge clock) disable iff (reset)
      hfill_ff <= HFILL_W'(POS_HISTORY))
      else $error("position history overfilled");

   a_cfill_max: assert property (@(posedge clock) disable iff (reset)
      cfill_ff <= CFILL_W'(CORNER_DEPTH))
      else $error("corner history overfilled");

   a_click_no_move: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && mode_ff == MODE_CLICK) |=> (mode_ff != MODE_MOVE))
      else $error("pending click jumped to move mode");

endmodule

// ===== rtl/hand_gesture_click_detector_unit.sv =====
`timescale 1ns / 1ps
// Hand gesture click detector.
// Request channel (req_valid / req_stall): one item per camera frame holding
// the raw hand position req_pos_x, req_pos_y and the corner count
// req_corner_count. Response channel (rsp_valid / rsp_stall): exactly one item
// per request with the event code, the mode after the frame and the smoothed
// cursor in Q10.6 (zero until a point has been stored).
// An item is taken at an edge with valid high and stall low.
// After the request is accepted, the smoothing divider (three quotient bits per cycle)
// runs its steps, then follow the click decision, the move check and the output load,
// after which the result is valid. The block takes one item at a time: a new item is
// accepted only once the previous one has been loaded into the output register.
// The output register frees the block to accept the next item while the
// previous result is still stalled; that item then waits in its last step
// until the result is taken.
// Configuration registers at byte address 4*i over the csr_ port; write them
// only while the block is idle.
// Reset (synchronous, active high) restores the register defaults, empties
// both histories and returns to normal mode.
module hand_gesture_click_detector_unit import hgcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [CORNER_W-1:0]   req_corner_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_event_res,
   output logic [1:0]            rsp_mode,
   output logic [CUR_W-1:0]      rsp_cursor_x,
   output logic [CUR_W-1:0]      rsp_cursor_y,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   cmd_type cmd;

   hgcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   hgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   hgcd_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .corner_count (req_corner_count),
      .event_res    (rsp_event_res),
      .mode         (rsp_mode),
      .cursor_x     (rsp_cursor_x),
      .cursor_y     (rsp_cursor_y)
   );

endmodule

// ===== test/hgcd_frame_checker.sv =====
`timescale 1ns / 1ps

module hgcd_frame_checker import hgcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [CORNER_W-1:0]   req_corner_count,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [2:0]            rsp_event_res,
   input  logic [1:0]            rsp_mode,
   input  logic [CUR_W-1:0]      rsp_cursor_x,
   input  logic [CUR_W-1:0]      rsp_cursor_y,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [2:0]       ev;
      logic [1:0]       md;
      logic [CUR_W-1:0] cx;
      logic [CUR_W-1:0] cy;
   } frame_report_type;

   frame_report_type due_reports[$];

   // shadow copy of the registers
   logic [11:0] margin_q;
   logic [9:0]  thresh_q;
   logic [3:0]  hold_lim_q;
   logic [3:0]  decay_lim_q;

   // shadow copy of the gesture state
   mode_type         mode_q;
   logic [CUR_W-1:0] pt_x [POS_HISTORY];
   logic [CUR_W-1:0] pt_y [POS_HISTORY];
   int unsigned      pt_fill;
   logic [CORNER_W-1:0] corner_q [CORNER_DEPTH];
   int unsigned      corner_fill_q;
   int unsigned      release_q;
   int unsigned      hold_q;
   int unsigned      quiet_q;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic clear_tracker();
      margin_q      = RST_DROP_MARGIN;
      thresh_q      = RST_MOVE_THRESH;
      hold_lim_q    = RST_HOLD_FRAMES;
      decay_lim_q   = RST_DECAY_FRAMES;
      mode_q        = MODE_NORMAL;
      pt_fill       = 0;
      corner_fill_q = 0;
      release_q     = 0;
      hold_q        = 0;
      quiet_q       = 0;
   endtask

   // append a smoothed point, dropping the oldest when full
   task automatic store_cursor(input int unsigned x, input int unsigned y);
      int i;
      if (pt_fill >= POS_HISTORY) begin
         for (i = 0; i < POS_HISTORY - 1; i++) begin
            pt_x[i] = pt_x[i+1];
            pt_y[i] = pt_y[i+1];
         end
         pt_fill = POS_HISTORY - 1;
      end
      pt_x[pt_fill] = x[CUR_W-1:0];
      pt_y[pt_fill] = y[CUR_W-1:0];
      pt_fill++;
   endtask

   // enter move mode on large travel, else decay toward normal
   task automatic check_motion();
      int unsigned last, dx, dy, n, limit;
      last  = pt_fill - 1;
      dx    = (pt_x[0] >= pt_x[last]) ? pt_x[0] - pt_x[last] : pt_x[last] - pt_x[0];
      dy    = (pt_y[0] >= pt_y[last]) ? pt_y[0] - pt_y[last] : pt_y[last] - pt_y[0];
      limit = thresh_q;
      limit = limit << FRAC_W;
      if (dx + dy > limit) begin
         mode_q  = MODE_MOVE;
         quiet_q = 0;
      end else if (mode_q == MODE_MOVE) begin
         n       = quiet_q + 1;
         quiet_q = (n > 15) ? 15 : n;
         if (n > decay_lim_q) mode_q = MODE_NORMAL;
      end else begin
         mode_q = MODE_NORMAL;
      end
   endtask

   // corner history: detect hand closing, opening and a held click
   task automatic check_corners(input logic [CORNER_W-1:0] c, inout event_type ev,
                                output bit consumed);
      int unsigned old_mean, new_mean, n, i;
      consumed = 1'b0;
      if (corner_fill_q < CORNER_DEPTH) begin
         corner_q[corner_fill_q] = c;
         corner_fill_q++;
      end else begin
         for (i = 0; i < CORNER_DEPTH - 1; i++) corner_q[i] = corner_q[i+1];
         corner_q[CORNER_DEPTH-1] = c;
         old_mean = 0;
         for (i = 0; i < 4; i++) old_mean += corner_q[i];
         old_mean = old_mean / 4;
         new_mean = corner_q[4];
         new_mean = (new_mean + corner_q[5]) / 2;
         if (mode_q == MODE_NORMAL && new_mean + margin_q < old_mean) begin
            release_q = new_mean;
            mode_q    = MODE_CLICK;
            hold_q    = 0;
            consumed  = 1'b1;
         end else if (new_mean > release_q + margin_q &&
                      (mode_q == MODE_DRAG || mode_q == MODE_CLICK)) begin
            ev       = (mode_q == MODE_DRAG) ? EV_UP : EV_CLICK;
            mode_q   = MODE_NORMAL;
            consumed = 1'b1;
         end else if (mode_q == MODE_CLICK) begin
            n      = hold_q + 1;
            hold_q = (n > 15) ? 15 : n;
            if (n > hold_lim_q) begin
               mode_q = MODE_DRAG;
               ev     = EV_DOWN;
               hold_q = 0;
            end
         end
      end
   endtask

   // advance the gesture state by one frame and form its report
   task automatic track_gesture(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                input logic [CORNER_W-1:0] c,
                                output frame_report_type r);
      int unsigned sx, sy, i;
      event_type   ev;
      bit          consumed;
      sx = x;
      sx = sx << FRAC_W;
      sy = y;
      sy = sy << FRAC_W;
      ev = EV_NONE;
      if (pt_fill > 0) begin
         for (i = 0; i < pt_fill; i++) begin
            sx += pt_x[i];
            sy += pt_y[i];
         end
         sx = sx / (pt_fill + 1);
         sy = sy / (pt_fill + 1);
      end
      case (mode_q)
         MODE_NORMAL: begin
            check_corners(c, ev, consumed);
            if (!consumed) begin
               store_cursor(sx, sy);
               ev = EV_MOVE;
               check_motion();
            end
         end
         MODE_MOVE: begin
            store_cursor(sx, sy);
            ev = EV_MOVE;
            check_motion();
         end
         MODE_DRAG: begin
            check_corners(c, ev, consumed);
            if (!consumed) begin
               store_cursor(sx, sy);
               ev = EV_DRAG;
            end
         end
         default: begin
            check_corners(c, ev, consumed);
         end
      endcase
      r.ev = ev;
      r.md = mode_q;
      r.cx = (pt_fill > 0) ? pt_x[pt_fill-1] : '0;
      r.cy = (pt_fill > 0) ? pt_y[pt_fill-1] : '0;
   endtask

   always @(posedge clock) begin : watch
      frame_report_type want;
      frame_report_type head;
      if (reset) begin
         clear_tracker();
         due_reports.delete();
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_DROP_MARGIN:  margin_q    = csr_pwdata[11:0];
               REG_MOVE_THRESH:  thresh_q    = csr_pwdata[9:0];
               REG_HOLD_FRAMES:  hold_lim_q  = csr_pwdata[3:0];
               REG_DECAY_FRAMES: decay_lim_q = csr_pwdata[3:0];
               default: ;
            endcase
         end
         // compare the item leaving the block with the oldest report due
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               $display("%0t: result item with no frame outstanding", $time);
               fail_count++;
            end else begin
               head = due_reports.pop_front();
               if (rsp_event_res !== head.ev) begin
                  $display("%0t: event expected %0d actual %0d", $time, head.ev,
                           rsp_event_res);
                  fail_count++;
               end
               if (rsp_mode !== head.md) begin
                  $display("%0t: mode expected %0d actual %0d", $time, head.md, rsp_mode);
                  fail_count++;
               end
               if (rsp_cursor_x !== head.cx) begin
                  $display("%0t: cursor_x expected %h actual %h", $time, head.cx,
                           rsp_cursor_x);
                  fail_count++;
               end
               if (rsp_cursor_y !== head.cy) begin
                  $display("%0t: cursor_y expected %h actual %h", $time, head.cy,
                           rsp_cursor_y);
                  fail_count++;
               end
            end
         end
         // predict each frame taken in
         if (req_valid && !req_stall) begin
            track_gesture(req_pos_x, req_pos_y, req_corner_count, want);
            due_reports.insert(due_reports.size(), want);
         end
      end
      pending_count <= due_reports.size();
   end

endmodule

// ===== test/hand_gesture_click_detector_unit_tb.sv =====
`timescale 1ns / 1ps

module hand_gesture_click_detector_unit_tb;
   import hgcd_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [POS_W-1:0]      req_pos_x;
   logic [POS_W-1:0]      req_pos_y;
   logic [CORNER_W-1:0]   req_corner_count;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_event_res;
   logic [1:0]            rsp_mode;
   logic [CUR_W-1:0]      rsp_cursor_x;
   logic [CUR_W-1:0]      rsp_cursor_y;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          fail_count;
   int          pending_frames;
   int          items_sent = 0;
   bit          req_gaps = 1'b1;
   bit          rsp_gaps = 1'b1;
   int unsigned cur_margin, cur_hold, cur_decay;
   int unsigned jitter = 0;
   int unsigned base_x = 512;
   int unsigned base_y = 512;

   hand_gesture_click_detector_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_corner_count (req_corner_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_mode         (rsp_mode),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   hgcd_frame_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_corner_count (req_corner_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_mode         (rsp_mode),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .fail_count       (fail_count),
      .pending_count    (pending_frames)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   // random backpressure on the result side
   always @(posedge clock) begin
      rsp_stall <= rsp_gaps && ($urandom_range(0, 99) < 33);
   end

   task automatic csr_write(input logic [1:0] idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every outstanding frame has reported
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
   endtask

   task automatic apply_config(input int unsigned m, input int unsigned t,
                               input int unsigned h, input int unsigned d);
      drain_results();
      csr_write(REG_DROP_MARGIN, m);
      csr_write(REG_MOVE_THRESH, t);
      csr_write(REG_HOLD_FRAMES, h);
      csr_write(REG_DECAY_FRAMES, d);
      cur_margin = m;
      cur_hold   = h;
      cur_decay  = d;
      jitter     = t / 6;
   endtask

   // present one frame, idling first at random, and wait until it is taken
   task automatic send_frame(input int unsigned x, input int unsigned y,
                             input int unsigned c);
      if (req_gaps) begin
         while ($urandom_range(0, 99) < 33) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_pos_x        <= x[POS_W-1:0];
      req_pos_y        <= y[POS_W-1:0];
      req_corner_count <= c[CORNER_W-1:0];
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic int unsigned near_pos(input int unsigned b);
      int unsigned p;
      p = b + $urandom_range(0, jitter);
      return (p > 1023) ? 1023 : p;
   endfunction

   // one gesture: mostly a clean close/hold/open, else a sweep or noise
   task automatic run_gesture();
      int unsigned kind, drop, base, low, n, k, i, c;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         drop = cur_margin + $urandom_range(1, 400);
         if (drop > 4095) drop = 4095;
         if ($urandom_range(0, 5) == 0) drop = drop / 2;
         base = $urandom_range(drop, 4095);
         low  = base - drop;
         n    = $urandom_range(4, 8);
         k    = $urandom_range(1, cur_hold + 4);
         for (i = 0; i < n; i++) send_frame(near_pos(base_x), near_pos(base_y), base);
         for (i = 0; i < k; i++) send_frame(near_pos(base_x), near_pos(base_y), low);
         n = $urandom_range(2, 5);
         for (i = 0; i < n; i++) send_frame(near_pos(base_x), near_pos(base_y), base);
      end else if (kind < 85) begin
         n = $urandom_range(3, 6);
         c = $urandom_range(0, 4095);
         for (i = 0; i < n; i++) begin
            base_x = $urandom_range(0, 1023);
            base_y = $urandom_range(0, 1023);
            send_frame(base_x, base_y, c);
         end
         // settle so that move mode decays
         n = cur_decay + $urandom_range(5, 8);
         for (i = 0; i < n; i++) send_frame(near_pos(base_x), near_pos(base_y), c);
      end else begin
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++)
            send_frame($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 4095));
      end
   endtask

   task automatic run_phase(input int unsigned m, input int unsigned t,
                            input int unsigned h, input int unsigned d,
                            input bit gaps, input int target);
      apply_config(m, t, h, d);
      req_gaps = gaps;
      rsp_gaps = gaps;
      while (items_sent < target) run_gesture();
   endtask

   initial begin
      int i;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_corner_count <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, then a click and a drag with short holds
      apply_config(100, 1023, 1, 0);
      send_frame(0, 0, 4095);
      send_frame(1023, 1023, 4095);
      send_frame(1023, 0, 0);
      send_frame(0, 1023, 4095);
      for (i = 0; i < 6; i++) send_frame(512, 512, 4095);
      send_frame(512, 512, 0);
      send_frame(512, 512, 0);
      send_frame(512, 512, 4095);
      send_frame(512, 512, 4095);
      send_frame(512, 512, 0);
      send_frame(512, 512, 0);
      for (i = 0; i < 3; i++) send_frame(520, 515, 0);
      send_frame(530, 520, 4095);
      send_frame(530, 520, 4095);

      // random gestures over several register settings
      run_phase(150, 12, 8, 10, 1'b1, 95);
      run_phase(0, 0, 0, 0, 1'b1, 165);
      run_phase(4095, 1023, 15, 15, 1'b0, 240);
      run_phase($urandom_range(0, 600), $urandom_range(0, 40), $urandom_range(0, 15),
                $urandom_range(0, 15), 1'b1, 315);
      run_phase(40, 3, 2, 1, 1'b1, 380);
      run_phase($urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 15),
                $urandom_range(0, 15), 1'b1, 440);

      drain_results();
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
